// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// They expect signals named clk and rst in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pscm_pkg.sv =====
package pscm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam int VALUE_W = 32;
  localparam int COMP_W  = VALUE_W + 1;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int ENTRY_W = VALUE_W + POS_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [COMP_W-1:0]  complement;
    logic                      done;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] partner;
    logic             overflow;
    logic             done;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } back_state_t;

endpackage

// ===== hdl/pair_sum_complement_match.sv =====
// Channel   Direction  Handshake        Payload
// input     in         push / full      element_value, end_of_array
// result    out        empty / pop      pair_hit, current_position, partner_position,
//                                       table_overflow, array_done
// config    in         target_sum_we    target_sum
//
// In the back end an element is taken in ST_IDLE, compared in ST_SCAN against each of
// the slots_used filled table slots, one slot a cycle through a single registered
// memory read port, and its result is issued in ST_DECIDE. Once a pair is found, or
// with an empty table, an element goes from ST_IDLE straight to ST_DECIDE. A two-entry
// queue and a one-entry result register let either side stall without stopping the
// other. Reset is synchronous and leaves the table empty with no clearing pass.
module pair_sum_complement_match (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 target_sum_we,
  input  logic signed [pscm_pkg::VALUE_W-1:0]  target_sum,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [pscm_pkg::VALUE_W-1:0]  element_value,
  input  logic                                 end_of_array,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 pair_hit,
  output logic [pscm_pkg::POS_W-1:0]           current_position,
  output logic [pscm_pkg::POS_W-1:0]           partner_position,
  output logic                                 table_overflow,
  output logic                                 array_done
);
  import pscm_pkg::*;

  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  result_t res;
  logic    res_valid;

  pscm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .target_sum_we (target_sum_we),
    .target_sum    (target_sum),
    .push          (push),
    .full          (full),
    .element_value (element_value),
    .end_of_array  (end_of_array),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_ready       (q_ready)
  );

  pscm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty            = !res_valid;
  assign pair_hit         = res.hit;
  assign current_position = res.position;
  assign partner_position = res.partner;
  assign table_overflow   = res.overflow;
  assign array_done       = res.done;

endmodule

// ===== hdl/pscm_ram.sv =====
module pscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pscm_front.sv =====
module pscm_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 target_sum_we,
  input  logic signed [pscm_pkg::VALUE_W-1:0]  target_sum,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [pscm_pkg::VALUE_W-1:0]  element_value,
  input  logic                                 end_of_array,
  output pscm_pkg::item_t                      q_item,
  output logic                                 q_valid,
  input  logic                                 q_ready
);
  import pscm_pkg::*;

  logic signed [VALUE_W-1:0] target;
  item_t                     entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]         wr_ptr;
  logic [QPTR_W-1:0]         rd_ptr;
  logic [QCNT_W-1:0]         count;
  logic                      do_push;
  logic                      do_pop;
  item_t                     new_item;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_ready;

  // The complement is formed one bit wider so that it never overflows.
  always_comb begin
    new_item.value      = element_value;
    new_item.complement = {target[VALUE_W-1], target}
                          - {element_value[VALUE_W-1], element_value};
    new_item.done       = end_of_array;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (target_sum_we) begin
        target <= target_sum;
      end
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= new_item;
    end
  end

endmodule

// ===== hdl/pscm_back.sv =====
module pscm_back (
  input  logic              clk,
  input  logic              rst,
  input  pscm_pkg::item_t   q_item,
  input  logic              q_valid,
  output logic              q_ready,
  output pscm_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_pop
);
  import pscm_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  item_t                cur;
  logic [SLOT_W-1:0]    scan_idx;
  logic [FILL_W-1:0]    slots_used;
  logic [COUNT_W-1:0]   element_counter;
  logic                 pair_found;
  logic                 comp_hit;
  logic [POS_W-1:0]     comp_pos;
  logic                 same_hit;
  logic [SLOT_W-1:0]    same_idx;

  logic [SLOT_W-1:0]    rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 we;
  logic [SLOT_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]   wr_data;

  logic [VALUE_W-1:0]   rd_value;
  logic [POS_W-1:0]     rd_pos;
  logic                 rd_comp_eq;
  logic                 rd_val_eq;
  logic                 last_slot;
  logic                 take;
  logic                 out_free;
  logic                 fire;
  logic                 has_room;
  logic                 need_new;
  result_t              res_next;

  pscm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_value   = rd_data[ENTRY_W-1 -: VALUE_W];
  assign rd_pos     = rd_data[POS_W-1:0];
  assign rd_comp_eq = ({rd_value[VALUE_W-1], rd_value} == cur.complement);
  assign rd_val_eq  = (rd_value == cur.value);
  assign last_slot  = ((FILL_W'(scan_idx) + FILL_W'(1)) == slots_used);
  assign out_free   = !res_valid || res_pop;
  assign take       = (state == ST_IDLE) && q_valid;
  assign fire       = (state == ST_DECIDE) && out_free;
  assign has_room   = (slots_used < FILL_W'(TABLE_DEPTH));
  assign need_new   = !pair_found && !comp_hit && !same_hit;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (pair_found || (slots_used == '0)) begin
            state_next = ST_DECIDE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    rd_addr = (state == ST_IDLE) ? '0 : scan_idx + SLOT_W'(1);

    res_next.hit      = !pair_found && comp_hit;
    res_next.position = element_counter[POS_W-1:0];
    res_next.partner  = res_next.hit ? comp_pos : '0;
    res_next.overflow = need_new && !has_room;
    res_next.done     = cur.done;

    we      = fire && !pair_found && !comp_hit && (same_hit || has_room);
    wr_addr = same_hit ? same_idx : slots_used[SLOT_W-1:0];
    wr_data = {cur.value, element_counter[POS_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      slots_used      <= '0;
      element_counter <= '0;
      pair_found      <= 1'b0;
      res_valid       <= 1'b0;
      comp_hit        <= 1'b0;
      same_hit        <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        comp_hit <= 1'b0;
        same_hit <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (rd_comp_eq) begin
          comp_hit <= 1'b1;
        end
        if (rd_val_eq) begin
          same_hit <= 1'b1;
        end
      end
      if (fire) begin
        res_valid <= 1'b1;
        if (cur.done) begin
          slots_used      <= '0;
          element_counter <= '0;
          pair_found      <= 1'b0;
        end else begin
          element_counter <= element_counter + COUNT_W'(1);
          if (res_next.hit) begin
            pair_found <= 1'b1;
          end
          if (need_new && has_room) begin
            slots_used <= slots_used + FILL_W'(1);
          end
        end
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Only the first match of each kind is kept, so the earliest slot wins.
  always_ff @(posedge clk) begin
    if (take) begin
      cur      <= q_item;
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + SLOT_W'(1);
      if (rd_comp_eq && !comp_hit) begin
        comp_pos <= rd_pos;
      end
      if (rd_val_eq && !same_hit) begin
        same_idx <= scan_idx;
      end
    end
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/pscm_checker.sv =====
`include "assert_macros.svh"

module pscm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input logic                        pair_hit,
  input logic [pscm_pkg::POS_W-1:0]  current_position,
  input logic [pscm_pkg::POS_W-1:0]  partner_position,
  input logic                        table_overflow
);
  import pscm_pkg::*;

  `ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(pair_hit) && $stable(current_position), "Waiting result changed before it was popped.")
  `ASSERT_IMP(a_partner_zero, !empty && !pair_hit, partner_position == '0, "Partner position is nonzero without a pair.")
  `ASSERT_IMP(a_hit_no_overflow, !empty && pair_hit, !table_overflow, "A pair result also reports a table overflow.")

endmodule

bind pair_sum_complement_match pscm_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .empty            (empty),
  .pop              (pop),
  .pair_hit         (pair_hit),
  .current_position (current_position),
  .partner_position (partner_position),
  .table_overflow   (table_overflow)
);
